@@ sv/lruc_pkg.sv @@
// ---------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants of the least-recently-used cache: the command
// and status groups between controller and datapath, and the stream widths.
// ---------------------------------------------------------------------------
`default_nettype none

package lruc_pkg;

    // width of every key and value field on the stream ports
    localparam int FIELD_W    = 32;
    localparam int S_TDATA_W  = 2 * FIELD_W;
    localparam int M_TDATA_W  = 2 * FIELD_W;
    localparam int M_TUSER_W  = 2;

    // bit positions of the flags in the result tuser
    localparam int TUSER_HIT     = 0;
    localparam int TUSER_EVICTED = 1;

    // width of the per-entry use stamp and of the use counter
    localparam int STAMP_W = 32;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture a new request and clear the scan trackers
        logic rd_en;    // read the entry at the scan address and step it
        logic finish;   // write back the touched entry and load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;      // no entry is valid
        logic last_addr;  // scan address is the last valid entry
        logic out_busy;   // result register holds an item not yet taken
    } t_sts;

endpackage

`default_nettype wire

@@ sv/lruc_ram.sv @@
// ---------------------------------------------------------------------------
// lruc_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lruc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/lruc_ctrl.sv @@
// ---------------------------------------------------------------------------
// lruc_ctrl
// Request sequencer: takes an item, scans the valid entries if there are any
// and compares the last read, then writes back and hands over the result.
// ---------------------------------------------------------------------------
`default_nettype none

module lruc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire lruc_pkg::t_sts i_sts,
    output lruc_pkg::t_cmd     o_cmd
);

    import lruc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.empty ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is compared in this cycle
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ sv/lruc_dp.sv @@
// ---------------------------------------------------------------------------
// lruc_dp
// Cache datapath: entry RAM, scan address, key match and oldest-entry
// trackers, occupancy and use counters, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lruc_dp #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lruc_pkg::t_cmd                     i_cmd,
    output lruc_pkg::t_sts                          o_sts,
    input  wire logic [lruc_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic      [lruc_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic      [lruc_pkg::M_TUSER_W-1:0]     o_m_axis_tuser
);

    import lruc_pkg::*;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS + STAMP_W;

    // request
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_fill;

    // counters
    logic [OCC_W-1:0]   r_occ;
    logic [STAMP_W-1:0] r_use_cnt;

    // scan
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;

    // trackers
    logic                  r_found;
    logic [IDX_W-1:0]      r_found_idx;
    logic [VALUE_BITS-1:0] r_found_val;
    logic                  r_vic_vld;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [KEY_BITS-1:0]   r_vic_key;
    logic [STAMP_W-1:0]    r_oldest;

    // result register
    logic               r_out_vld;
    logic [FIELD_W-1:0] r_out_value;
    logic [FIELD_W-1:0] r_out_ev_key;
    logic               r_out_hit;
    logic               r_out_evicted;

    // ram ports
    logic [ENTRY_W-1:0]    w_rd_data;
    logic [KEY_BITS-1:0]   w_rd_key;
    logic [VALUE_BITS-1:0] w_rd_val;
    logic [STAMP_W-1:0]    w_rd_stamp;
    logic [STAMP_W-1:0]    w_age;
    logic                  w_full;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [ENTRY_W-1:0]    w_wr_data;
    logic [VALUE_BITS-1:0] w_wr_val;

    // entry layout: key, value, last-use stamp from the top bit down
    assign w_rd_key   = w_rd_data[ENTRY_W-1 -: KEY_BITS];
    assign w_rd_val   = w_rd_data[STAMP_W +: VALUE_BITS];
    assign w_rd_stamp = w_rd_data[STAMP_W-1:0];
    assign w_age      = r_use_cnt - w_rd_stamp;

    // entries fill from index 0 and are never freed, so valid is below r_occ
    assign w_full = (r_occ == OCC_W'(ENTRIES));

    // write back: refresh the hit entry, or fill the free slot or the victim
    assign w_wr_en   = i_cmd.finish;
    assign w_wr_val  = r_found ? r_found_val : r_fill;
    assign w_wr_data = {r_key, w_wr_val, r_use_cnt};
    always_comb begin
        if (r_found) begin
            w_wr_addr = r_found_idx;
        end else if (!w_full) begin
            w_wr_addr = IDX_W'(r_occ);
        end else begin
            w_wr_addr = r_vic_idx;
        end
    end

    lruc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    // status to the controller
    assign o_sts.empty     = (r_occ == '0);
    assign o_sts.last_addr = ((OCC_W'(r_addr) + OCC_W'(1)) == r_occ);
    assign o_sts.out_busy  = r_out_vld && !i_m_axis_tready;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key  <= KEY_BITS'(i_s_axis_tdata[FIELD_W-1:0]);
            r_fill <= VALUE_BITS'(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]);
        end
    end

    // scan address and read-data valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.accept) begin
                r_addr <= '0;
            end else if (i_cmd.rd_en) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_idx <= r_addr;
        end
    end

    // key match and oldest-entry tracking, lowest index wins ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_vic_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_found   <= 1'b0;
            r_vic_vld <= 1'b0;
        end else if (r_rd_vld) begin
            if (!r_found && (w_rd_key == r_key)) begin
                r_found <= 1'b1;
            end
            if (!r_vic_vld || (w_age > r_oldest)) begin
                r_vic_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (!r_found && (w_rd_key == r_key)) begin
                r_found_idx <= r_rd_idx;
                r_found_val <= w_rd_val;
            end
            if (!r_vic_vld || (w_age > r_oldest)) begin
                r_vic_idx <= r_rd_idx;
                r_vic_key <= w_rd_key;
                r_oldest  <= w_age;
            end
        end
    end

    // occupancy and use counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_use_cnt <= '0;
        end else if (i_cmd.finish) begin
            r_use_cnt <= r_use_cnt + STAMP_W'(1);
            if (!r_found && !w_full) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value   <= FIELD_W'(w_wr_val);
            r_out_hit     <= r_found;
            r_out_evicted <= !r_found && w_full;
            r_out_ev_key  <= (!r_found && w_full) ? FIELD_W'(r_vic_key) : '0;
        end
    end

    assign o_m_axis_tvalid                = r_out_vld;
    assign o_m_axis_tdata                 = {r_out_ev_key, r_out_value};
    assign o_m_axis_tuser[TUSER_HIT]      = r_out_hit;
    assign o_m_axis_tuser[TUSER_EVICTED]  = r_out_evicted;

`ifndef SYNTHESIS
    // occupancy never passes the table size
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(ENTRIES))
        else $error("occupancy above table size");

    // an eviction only happens on a miss into a full table
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !w_full) |=> !r_out_evicted)
        else $error("eviction with a free slot");

    // a result is never both a hit and an eviction
    a_hit_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_hit && r_out_evicted))
        else $error("hit and eviction together");

    // the use counter moves only when a request completes
    a_use_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.finish |=> $stable(r_use_cnt))
        else $error("use counter moved without a request");

    // no write-back while the scan still reads
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.finish && (i_cmd.rd_en || r_rd_vld)))
        else $error("write-back during scan");
`endif

endmodule

`default_nettype wire

@@ sv/lru_cache.sv @@
// ---------------------------------------------------------------------------
// lru_cache
// Fully associative least-recently-used cache. Each request carries a key
// and its backing-store value; a hit returns the cached value, a miss
// returns the fill value and inserts the key, evicting the oldest entry
// when the table is full.
//
//   channel   dir  signals                 contents (lowest bit up)
//   s_axis    in   tvalid tready tdata     tdata: key[31:0], fill_value[63:32]
//   m_axis    out  tvalid tready tdata     tdata: value[31:0], evicted_key[63:32]
//                  tuser                   tuser: hit[0], evicted[1]
//
// an item is accepted, then each valid entry is read from the entry RAM in
// turn, the last read is compared and the entry is written back; the single
// RAM read port sets the scan length
// an empty table skips the scan and the compare
// a new item is accepted while the previous result still waits downstream;
// write-back waits until the result register is free
// synchronous active-low reset empties the table and clears the use counter;
// no clearing pass is needed
// ---------------------------------------------------------------------------
`default_nettype none

module lru_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key, fill_value
    input  wire logic [lruc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // value, evicted_key
    output logic      [lruc_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // hit, evicted
    output logic      [lruc_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    import lruc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // request sequencer
    lruc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    // entry storage, compare and result
    lruc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
